### rtl/bucketed_hash_table_defines.svh
// ----------------------------------------------------------------------------
// bucketed hash table assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define BHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define BHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BHT_ASSERT(lbl, prop, msg)
`define BHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/bht_pkg.sv
// ----------------------------------------------------------------------------
// bht_pkg
// types and fixed widths for the bucketed hash table
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

  localparam int KeyW    = 31;
  localparam int OpW     = 2;
  localparam int ProbesW = 5;
  localparam int RecipW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_HASH1  = 6'b000100,
    ST_HASH2  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_e;

endpackage

`default_nettype wire

### rtl/bucketed_hash_table.sv
// ----------------------------------------------------------------------------
// bucketed_hash_table
// set-associative table of keys, one bucket row read, compared and written back
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid_i / in_stall_o with operation_i (insert, search,
//   remove) and key_i. output channel: out_valid_o / out_stall_i with
//   success_o and probes_o, exactly one result beat per request beat.
//   The bucket is key_i mod NUM_BUCKETS; one memory row holds the SLOTS keys
//   and valid bits of a bucket, so a request is one row read, a parallel
//   compare of all slots and at most one row write (none for a search).
//   From input beat to result beat a request passes ST_READ and ST_UPDATE
//   when NUM_BUCKETS is a power of two, and ST_HASH1 and ST_HASH2 before
//   them otherwise (two multiply stages of the modulo unit). One request is
//   in flight at a time, so the rate is set by the row read and the modulo
//   unit. After reset a clearing pass writes every row empty, with
//   in_stall_o high. A result waits in the output register while
//   out_stall_i is high; the next request is already taken and finishes
//   its compare, holding off the write-back until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bucketed_hash_table_defines.svh"

module bucketed_hash_table #(
  parameter int NUM_BUCKETS = 128,
  parameter int SLOTS       = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bht_pkg::OpW-1:0]      operation_i,
  input  logic [bht_pkg::KeyW-1:0]     key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         success_o,
  output logic [bht_pkg::ProbesW-1:0]  probes_o
);

  import bht_pkg::*;

  localparam int  IdxW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int  SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int  EntryW = KeyW + 1;
  localparam int  RowW   = SLOTS * EntryW;
  localparam bit  IsPow2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

  state_e state_q, state_d;

  op_e               op_q;
  logic [KeyW-1:0]   key_q;
  logic [IdxW-1:0]   bucket;
  logic [IdxW-1:0]   bucket_q;
  logic [IdxW-1:0]   clr_cnt_q, clr_cnt_d;

  logic [RowW-1:0]   bucket_mem [NUM_BUCKETS];
  logic [RowW-1:0]   rdata_q;
  logic              mem_re;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [RowW-1:0]   mem_wdata;

  logic [SLOTS-1:0]  hit_vec;
  logic [SLOTS-1:0]  free_vec;
  logic [SLOTS-1:0]  sel_vec;
  logic              found;
  logic [SlotW-1:0]  found_idx;
  logic [RowW-1:0]   new_row;

  logic              in_fire;
  logic              out_fire;
  logic              upd_go;
  logic              out_valid_q, out_valid_d;
  logic              success_q;
  logic [ProbesW-1:0] probes_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign upd_go   = (state_q == ST_UPDATE) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign success_o   = success_q;
  assign probes_o    = probes_q;

  // bucket index: key mod NUM_BUCKETS
  if (NUM_BUCKETS == 1) begin : g_one_bucket
    assign bucket = '0;
  end else if (IsPow2) begin : g_pow2_bucket
    assign bucket = key_q[IdxW-1:0];
  end else begin : g_mod_bucket
    // quotient estimate by reciprocal, never above the true quotient and
    // at most one below, so one compare and subtract finishes the remainder
    localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << 31) / NUM_BUCKETS);
    logic [KeyW+RecipW-1:0] prod_q;
    logic [KeyW-1:0]        q_est;
    logic [KeyW-1:0]        qn_q;
    logic [IdxW:0]          r_est;

    assign q_est = prod_q[KeyW+RecipW-2:RecipW-1];

    always_ff @(posedge clk_i) begin
      prod_q <= (KeyW+RecipW)'(key_q) * (KeyW+RecipW)'(Recip);
      qn_q   <= KeyW'(q_est * KeyW'(NUM_BUCKETS));
    end

    always_comb begin
      r_est = (IdxW+1)'(key_q - qn_q);
      if (r_est >= (IdxW+1)'(NUM_BUCKETS)) begin
        r_est = r_est - (IdxW+1)'(NUM_BUCKETS);
      end
      bucket = r_est[IdxW-1:0];
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(operation_i);
      key_q <= key_i;
    end
    if (state_q == ST_READ) begin
      bucket_q <= bucket;
    end
  end

  // slot compare over the row that was read
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      free_vec[j] = !rdata_q[j*EntryW + KeyW];
      hit_vec[j]  = rdata_q[j*EntryW + KeyW] && (rdata_q[j*EntryW +: KeyW] == key_q);
    end
    case (op_q)
      OP_INSERT: sel_vec = free_vec;
      OP_SEARCH: sel_vec = hit_vec;
      OP_REMOVE: sel_vec = hit_vec;
      default:   sel_vec = '0;
    endcase
    found     = 1'b0;
    found_idx = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (sel_vec[j]) begin
        found     = 1'b1;
        found_idx = SlotW'(j);
      end
    end
    new_row = rdata_q;
    for (int j = 0; j < SLOTS; j++) begin
      if (found && (found_idx == SlotW'(j))) begin
        if (op_q == OP_INSERT) begin
          new_row[j*EntryW +: KeyW] = key_q;
          new_row[j*EntryW + KeyW]  = 1'b1;
        end else if (op_q == OP_REMOVE) begin
          new_row[j*EntryW + KeyW]  = 1'b0;
        end
      end
    end
  end

  // memory port control
  always_comb begin
    mem_re    = (state_q == ST_READ);
    mem_we    = 1'b0;
    mem_waddr = bucket_q;
    mem_wdata = new_row;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (upd_go && found && (op_q != OP_SEARCH)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bucket_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bucket_mem[bucket];
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IdxW'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = IsPow2 ? ST_READ : ST_HASH1;
        end
      end
      ST_HASH1:  state_d = ST_HASH2;
      ST_HASH2:  state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (upd_go) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      success_q <= found;
      probes_q  <= found ? (ProbesW'(found_idx) + ProbesW'(1)) : ProbesW'(SLOTS);
    end
  end

  `BHT_ASSERT(a_we_state, mem_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE), "row write outside clear or update")
  `BHT_ASSERT(a_upd_hold, (state_q == ST_UPDATE && out_valid_q && out_stall_i) |=> (state_q == ST_UPDATE && !mem_we) || (state_q == ST_UPDATE && $past(!mem_we)), "update left while output full")
  `BHT_ASSERT(a_accept_next, in_fire |=> (state_q == ST_HASH1 || state_q == ST_READ), "accepted request did not start")
  `BHT_ASSERT(a_probes_range, out_valid_o |-> (probes_o != '0 && probes_o <= ProbesW'(SLOTS)), "probe count out of range")
  `BHT_ASSERT_ALWAYS(a_state_onehot, !rst_ni || $onehot(state_q), "sequencer state not one-hot")

endmodule

`default_nettype wire
